// ===== hdl/crn_pkg.sv =====
// ----------------------------------------------------------------------------
// crn_pkg: shared types and constants for the crop/resize/normalize block
// Holds the transaction payloads, the configuration record, the queue entry
// format and the fixed-point constants of the ImageNet normalization.
// ----------------------------------------------------------------------------
package crn_pkg;

    // Configuration port geometry and register indexes.
    localparam int CfgIndexW = 3;
    localparam int CfgDataW  = 16;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_PIXEL_FORMAT = 3'd0,
        CFG_FRAME_WIDTH  = 3'd1,
        CFG_FRAME_HEIGHT = 3'd2,
        CFG_ROW_PITCH    = 3'd3,
        CFG_CHROMA_PITCH = 3'd4
    } cfg_index_t;

    // Frame formats and item kinds.
    localparam logic FMT_NV12     = 1'b0;
    localparam logic FMT_RGBA     = 1'b1;
    localparam logic FUNC_MAP     = 1'b0;
    localparam logic FUNC_CONVERT = 1'b1;

    // Datapath widths.
    localparam int CoordW = 14;
    localparam int AddrW  = 28;
    localparam int ProdW  = 21;
    localparam int NormW  = 16;

    // Queue between front and back.
    localparam int QueueDepth = 4;
    localparam int QueueIdxW  = 2;

    typedef struct packed {
        logic        pixel_format;
        logic [13:0] frame_width;
        logic [13:0] frame_height;
        logic [15:0] row_pitch;
        logic [15:0] chroma_pitch;
    } cfg_t;

    typedef struct packed {
        logic        func;
        logic [12:0] crop_left;
        logic [12:0] crop_top;
        logic [13:0] crop_right;
        logic [13:0] crop_bottom;
        logic [5:0]  out_col;
        logic [5:0]  out_row;
        logic [7:0]  luma_or_red;
        logic [7:0]  cb_or_green;
        logic [7:0]  cr_or_blue;
    } in_item_t;

    typedef struct packed {
        logic [AddrW-1:0]        pixel_address;
        logic [AddrW-1:0]        chroma_address;
        logic                    empty_crop;
        logic signed [NormW-1:0] red_norm;
        logic signed [NormW-1:0] green_norm;
        logic signed [NormW-1:0] blue_norm;
    } out_item_t;

    // Classified item as it waits for the back end.
    typedef struct packed {
        logic             func;
        logic             empty;
        logic [12:0]      x1;
        logic [12:0]      y1;
        logic [ProdW-1:0] prod_x;
        logic [ProdW-1:0] prod_y;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
    } q_item_t;

    // Normalization: out = floor(c * Gain - Off + Half) >> NormFrac, where
    // Gain = 4096000 / (255 * std) and Off = 4096 * 255 * mean / (255 * std),
    // both scaled by 2^NormFrac. The scaled error stays far below the gap to
    // the nearest rounding tie.
    localparam int NormFrac  = 28;
    localparam int NormGainW = 36;
    localparam int NormOffW  = 42;
    localparam int NormProdW = 44;
    localparam int NormValW  = 46;

    localparam logic [63:0] NormOne  = 64'd1 << NormFrac;
    localparam logic [63:0] NormDenR = 64'd58395;
    localparam logic [63:0] NormDenG = 64'd57120;
    localparam logic [63:0] NormDenB = 64'd57375;

    localparam logic [NormGainW-1:0] NormGainR =
        NormGainW'((64'd4096000 * NormOne + NormDenR / 64'd2) / NormDenR);
    localparam logic [NormGainW-1:0] NormGainG =
        NormGainW'((64'd4096000 * NormOne + NormDenG / 64'd2) / NormDenG);
    localparam logic [NormGainW-1:0] NormGainB =
        NormGainW'((64'd4096000 * NormOne + NormDenB / 64'd2) / NormDenB);

    localparam logic [NormOffW-1:0] NormOffR =
        NormOffW'((64'd4096 * 64'd255 * 64'd485 * NormOne + NormDenR / 64'd2) / NormDenR);
    localparam logic [NormOffW-1:0] NormOffG =
        NormOffW'((64'd4096 * 64'd255 * 64'd456 * NormOne + NormDenG / 64'd2) / NormDenG);
    localparam logic [NormOffW-1:0] NormOffB =
        NormOffW'((64'd4096 * 64'd255 * 64'd406 * NormOne + NormDenB / 64'd2) / NormDenB);

    localparam logic [NormValW-1:0] NormHalf = NormValW'(64'd1 << (NormFrac - 1));

endpackage

// ===== hdl/crn_in_if.sv =====
// ----------------------------------------------------------------------------
// crn_in_if: input channel
// Valid/ready channel that carries one map or convert item per transaction.
// ----------------------------------------------------------------------------
interface crn_in_if;
    logic               valid;
    logic               ready;
    crn_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/crn_out_if.sv =====
// ----------------------------------------------------------------------------
// crn_out_if: result channel
// Valid/ready channel that carries one result per transaction.
// ----------------------------------------------------------------------------
interface crn_out_if;
    logic                valid;
    logic                ready;
    crn_pkg::out_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/crop_resize_nv12_normalize_top.sv =====
// ----------------------------------------------------------------------------
// crop_resize_nv12_normalize_top: crop, nearest-neighbour resize and normalize
// Map items give NV12 or RGBA fetch addresses of a cropped, resized frame;
// convert items give ImageNet-normalized RGB in signed Q4.12.
//
//   Channel   Kind          Width  Transfer
//   item      sink          91     valid && ready
//   result    source        105    valid && ready
//   cfg       write port    3+16   cfg_wr_en
//
// One item per cycle sustained while result.ready holds. The queue entry is
// written at the accepting edge itself; the item then passes through the
// three back stages, s1, s2 and the result register, before result.valid rises.
// Reset clears the queue and all stage valid flags and loads the default
// frame geometry. A stalled result fills the back stages and then the
// four-entry queue; item.ready drops only once the queue is full.
// ----------------------------------------------------------------------------
module crop_resize_nv12_normalize_top #(
    parameter int OUTPUT_SIZE = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    crn_in_if.sink                         item,
    crn_out_if.source                      result,
    input  logic                           cfg_wr_en,
    input  logic [crn_pkg::CfgIndexW-1:0]  cfg_index,
    input  logic [crn_pkg::CfgDataW-1:0]   cfg_data
);

    crn_pkg::cfg_t     cfg_reg;
    crn_pkg::cfg_t     cfg_next;
    logic              queue_full;
    logic              push;
    crn_pkg::q_item_t  push_item;
    logic              pop;
    logic              head_valid;
    crn_pkg::q_item_t  head_item;

    // Configuration register writes; unknown indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                crn_pkg::CFG_PIXEL_FORMAT: cfg_next.pixel_format = cfg_data[0];
                crn_pkg::CFG_FRAME_WIDTH:  cfg_next.frame_width  = cfg_data[13:0];
                crn_pkg::CFG_FRAME_HEIGHT: cfg_next.frame_height = cfg_data[13:0];
                crn_pkg::CFG_ROW_PITCH:    cfg_next.row_pitch    = cfg_data;
                crn_pkg::CFG_CHROMA_PITCH: cfg_next.chroma_pitch = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_format <= crn_pkg::FMT_NV12;
            cfg_reg.frame_width  <= 14'd1920;
            cfg_reg.frame_height <= 14'd1080;
            cfg_reg.row_pitch    <= 16'd1920;
            cfg_reg.chroma_pitch <= 16'd1920;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: intake and classification.
    crn_front u_front (
        .item         (item),
        .pixel_format (cfg_reg.pixel_format),
        .queue_full   (queue_full),
        .push         (push),
        .push_item    (push_item)
    );

    // Queue between the two sides.
    crn_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // Back end: execution pipeline and result register.
    crn_back #(
        .OUTPUT_SIZE (OUTPUT_SIZE)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (head_valid),
        .q_item  (head_item),
        .q_pop   (pop),
        .result  (result)
    );

endmodule

// ===== hdl/crn_front.sv =====
// ----------------------------------------------------------------------------
// crn_front: item intake and classification
// Accepts input transactions while the queue has room, flags empty crops,
// forms the scaled position products and does the BT.601 color conversion of NV12 items.
// ----------------------------------------------------------------------------
module crn_front (
    crn_in_if.sink             item,
    input  logic               pixel_format,
    input  logic               queue_full,
    output logic               push,
    output crn_pkg::q_item_t   push_item
);

    logic signed [14:0] width_s;
    logic signed [14:0] height_s;
    logic [6:0]         col_odd;
    logic [6:0]         row_odd;
    logic signed [8:0]  u_s;
    logic signed [8:0]  v_s;
    logic signed [17:0] r_term;
    logic signed [17:0] g_term;
    logic signed [17:0] b_term;
    logic signed [10:0] r_sum;
    logic signed [10:0] g_sum;
    logic signed [10:0] b_sum;

    function automatic logic [7:0] clamp_byte(input logic signed [10:0] v);
        logic [7:0] res;
        if (v < 11'sd0)
        begin
            res = 8'd0;
        end
        else if (v > 11'sd255)
        begin
            res = 8'd255;
        end
        else
        begin
            res = v[7:0];
        end
        return res;
    endfunction

    // Handshake: a transaction goes straight into the queue.
    assign item.ready = !queue_full;
    assign push       = item.valid && !queue_full;

    // Crop size and the numerator (2*pos+1)*len of the nearest-neighbour map.
    always_comb
    begin
        width_s  = signed'({1'b0, item.data.crop_right}) - signed'({2'b00, item.data.crop_left});
        height_s = signed'({1'b0, item.data.crop_bottom}) - signed'({2'b00, item.data.crop_top});
        col_odd  = {item.data.out_col, 1'b1};
        row_odd  = {item.data.out_row, 1'b1};
    end

    // Integer BT.601; the shifts round toward minus infinity.
    always_comb
    begin
        u_s    = signed'({1'b0, item.data.cb_or_green}) - 9'sd128;
        v_s    = signed'({1'b0, item.data.cr_or_blue}) - 9'sd128;
        r_term = 18'sd359 * v_s;
        g_term = 18'sd88 * u_s + 18'sd183 * v_s;
        b_term = 18'sd454 * u_s;
        r_sum  = signed'({3'b000, item.data.luma_or_red}) + 11'(r_term >>> 8);
        g_sum  = signed'({3'b000, item.data.luma_or_red}) - 11'(g_term >>> 8);
        b_sum  = signed'({3'b000, item.data.luma_or_red}) + 11'(b_term >>> 8);
    end

    // Queue entry.
    always_comb
    begin
        push_item.func   = item.data.func;
        push_item.empty  = (width_s <= 15'sd0) || (height_s <= 15'sd0);
        push_item.x1     = item.data.crop_left;
        push_item.y1     = item.data.crop_top;
        push_item.prod_x = crn_pkg::ProdW'(col_odd * width_s[13:0]);
        push_item.prod_y = crn_pkg::ProdW'(row_odd * height_s[13:0]);
        if (pixel_format == crn_pkg::FMT_NV12)
        begin
            push_item.red   = clamp_byte(r_sum);
            push_item.green = clamp_byte(g_sum);
            push_item.blue  = clamp_byte(b_sum);
        end
        else
        begin
            push_item.red   = item.data.luma_or_red;
            push_item.green = item.data.cb_or_green;
            push_item.blue  = item.data.cr_or_blue;
        end
    end

endmodule

// ===== hdl/crn_fifo.sv =====
// ----------------------------------------------------------------------------
// crn_fifo: queue between front and back
// Small register queue of classified items; push and pop may share a cycle.
// ----------------------------------------------------------------------------
module crn_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  crn_pkg::q_item_t  push_item,
    input  logic              pop,
    output logic              full,
    output logic              head_valid,
    output crn_pkg::q_item_t  head_item
);

    crn_pkg::q_item_t                 entry_reg [crn_pkg::QueueDepth];
    logic [crn_pkg::QueueIdxW-1:0]    wr_ptr_reg;
    logic [crn_pkg::QueueIdxW-1:0]    wr_ptr_next;
    logic [crn_pkg::QueueIdxW-1:0]    rd_ptr_reg;
    logic [crn_pkg::QueueIdxW-1:0]    rd_ptr_next;
    logic [crn_pkg::QueueIdxW:0]      count_reg;
    logic [crn_pkg::QueueIdxW:0]      count_next;

    assign full       = (count_reg == (crn_pkg::QueueIdxW + 1)'(crn_pkg::QueueDepth));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/crn_back.sv =====
// ----------------------------------------------------------------------------
// crn_back: execution pipeline
// Three stages: reciprocal and gain multiplies, offset/clamp, then address
// multiplies into the result register.
// ----------------------------------------------------------------------------
module crn_back #(
    parameter int OUTPUT_SIZE = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  crn_pkg::cfg_t     cfg,
    input  logic              q_valid,
    input  crn_pkg::q_item_t  q_item,
    output logic              q_pop,
    crn_out_if.source         result
);

    // Division by 2*OUTPUT_SIZE as a multiply by a rounded-up reciprocal;
    // exact for every numerator below 2^ProdW.
    localparam int Divisor    = 2 * OUTPUT_SIZE;
    localparam int RecipShift = 30;
    localparam logic [RecipShift-1:0] RecipMul =
        RecipShift'((2 ** RecipShift + Divisor - 1) / Divisor);
    localparam int RecipW = crn_pkg::ProdW + RecipShift;
    localparam int SumW   = crn_pkg::ProdW + 1;
    localparam int MulW   = 30;

    typedef struct packed {
        logic                              func;
        logic                              empty;
        logic [12:0]                       x1;
        logic [12:0]                       y1;
        logic [crn_pkg::ProdW-1:0]         quot_x;
        logic [crn_pkg::ProdW-1:0]         quot_y;
        logic [crn_pkg::NormProdW-1:0]     prod_r;
        logic [crn_pkg::NormProdW-1:0]     prod_g;
        logic [crn_pkg::NormProdW-1:0]     prod_b;
    } s1_t;

    typedef struct packed {
        logic                              func;
        logic                              empty;
        logic [crn_pkg::CoordW-1:0]        ix;
        logic [crn_pkg::CoordW-1:0]        iy;
        logic signed [crn_pkg::NormW-1:0]  red;
        logic signed [crn_pkg::NormW-1:0]  green;
        logic signed [crn_pkg::NormW-1:0]  blue;
    } s2_t;

    s1_t                 s1_reg;
    s1_t                 s1_next;
    logic                s1_valid_reg;
    s2_t                 s2_reg;
    s2_t                 s2_next;
    logic                s2_valid_reg;
    crn_pkg::out_item_t  out_reg;
    crn_pkg::out_item_t  out_next;
    logic                out_valid_reg;

    logic                s1_en;
    logic                s2_en;
    logic                out_en;

    logic [RecipW-1:0]   recip_x;
    logic [RecipW-1:0]   recip_y;

    logic [SumW-1:0]             sum_x;
    logic [SumW-1:0]             sum_y;
    logic [crn_pkg::CoordW-1:0]  hi_x;
    logic [crn_pkg::CoordW-1:0]  hi_y;
    logic signed [crn_pkg::NormValW-1:0] val_r;
    logic signed [crn_pkg::NormValW-1:0] val_g;
    logic signed [crn_pkg::NormValW-1:0] val_b;

    logic [MulW-1:0]             luma_prod;
    logic [MulW-1:0]             chroma_prod;

    // Stage enables: a stage moves when its successor is empty or moving.
    assign out_en = !out_valid_reg || result.ready;
    assign s2_en  = !s2_valid_reg || out_en;
    assign s1_en  = !s1_valid_reg || s2_en;
    assign q_pop  = q_valid && s1_en;

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    // Stage 1: reciprocal multiply for the map and gain multiply for convert.
    always_comb
    begin
        recip_x        = RecipW'(q_item.prod_x) * RecipW'(RecipMul);
        recip_y        = RecipW'(q_item.prod_y) * RecipW'(RecipMul);
        s1_next.func   = q_item.func;
        s1_next.empty  = q_item.empty;
        s1_next.x1     = q_item.x1;
        s1_next.y1     = q_item.y1;
        s1_next.quot_x = recip_x[RecipW-1:RecipShift];
        s1_next.quot_y = recip_y[RecipW-1:RecipShift];
        s1_next.prod_r = crn_pkg::NormProdW'(q_item.red) * crn_pkg::NormProdW'(crn_pkg::NormGainR);
        s1_next.prod_g = crn_pkg::NormProdW'(q_item.green) * crn_pkg::NormProdW'(crn_pkg::NormGainG);
        s1_next.prod_b = crn_pkg::NormProdW'(q_item.blue) * crn_pkg::NormProdW'(crn_pkg::NormGainB);
    end

    // Stage 2: offset and clamp of the coordinates, offset and rounding of the norms.
    always_comb
    begin
        sum_x = SumW'(s1_reg.x1) + SumW'(s1_reg.quot_x);
        sum_y = SumW'(s1_reg.y1) + SumW'(s1_reg.quot_y);
        hi_x  = (cfg.frame_width == '0) ? '0 : cfg.frame_width - 1'b1;
        hi_y  = (cfg.frame_height == '0) ? '0 : cfg.frame_height - 1'b1;
        val_r = signed'(crn_pkg::NormValW'(s1_reg.prod_r))
              - signed'(crn_pkg::NormValW'(crn_pkg::NormOffR)) + signed'(crn_pkg::NormHalf);
        val_g = signed'(crn_pkg::NormValW'(s1_reg.prod_g))
              - signed'(crn_pkg::NormValW'(crn_pkg::NormOffG)) + signed'(crn_pkg::NormHalf);
        val_b = signed'(crn_pkg::NormValW'(s1_reg.prod_b))
              - signed'(crn_pkg::NormValW'(crn_pkg::NormOffB)) + signed'(crn_pkg::NormHalf);

        s2_next.func  = s1_reg.func;
        s2_next.empty = s1_reg.empty;
        s2_next.ix    = (sum_x > SumW'(hi_x)) ? hi_x : sum_x[crn_pkg::CoordW-1:0];
        s2_next.iy    = (sum_y > SumW'(hi_y)) ? hi_y : sum_y[crn_pkg::CoordW-1:0];
        s2_next.red   = val_r[crn_pkg::NormFrac+crn_pkg::NormW-1:crn_pkg::NormFrac];
        s2_next.green = val_g[crn_pkg::NormFrac+crn_pkg::NormW-1:crn_pkg::NormFrac];
        s2_next.blue  = val_b[crn_pkg::NormFrac+crn_pkg::NormW-1:crn_pkg::NormFrac];
    end

    // Stage 3: byte addresses and result assembly.
    always_comb
    begin
        luma_prod   = MulW'(s2_reg.iy) * MulW'(cfg.row_pitch);
        chroma_prod = MulW'(s2_reg.iy[crn_pkg::CoordW-1:1]) * MulW'(cfg.chroma_pitch);
        out_next    = '0;
        if (s2_reg.func == crn_pkg::FUNC_MAP)
        begin
            if (s2_reg.empty)
            begin
                out_next.empty_crop = 1'b1;
            end
            else if (cfg.pixel_format == crn_pkg::FMT_NV12)
            begin
                out_next.pixel_address  = luma_prod[crn_pkg::AddrW-1:0]
                                        + crn_pkg::AddrW'(s2_reg.ix);
                out_next.chroma_address = chroma_prod[crn_pkg::AddrW-1:0]
                                        + crn_pkg::AddrW'({s2_reg.ix[crn_pkg::CoordW-1:1], 1'b0});
            end
            else
            begin
                out_next.pixel_address  = luma_prod[crn_pkg::AddrW-1:0]
                                        + crn_pkg::AddrW'({s2_reg.ix, 2'b00});
            end
        end
        else
        begin
            out_next.red_norm   = s2_reg.red;
            out_next.green_norm = s2_reg.green;
            out_next.blue_norm  = s2_reg.blue;
        end
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_valid_reg <= q_valid;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_en)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_reg <= s1_next;
        end
        if (s2_en)
        begin
            s2_reg <= s2_next;
        end
        if (out_en)
        begin
            out_reg <= out_next;
        end
    end

endmodule
